// ===== src/assert_macros.svh =====
// assertion macros shared by the slot table rtl
// depends on nothing; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define FLST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table check failed");

// next-cycle implication, checked outside reset
`define FLST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table check failed");

`else

`define FLST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FLST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/flst_pkg.sv =====
// types, constants and codes of the slot table
// depends on nothing; used by free_list_slot_table, flst_ctrl and flst_datapath
package flst_pkg;

    localparam int ENTRIES = 16384;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    localparam logic [15:0]      END_MARK  = 16'hFFFF;
    localparam logic [16:0]      ENTRY_LIM = 17'(ENTRIES);
    localparam logic [CNT_W-1:0] COUNT_LIM = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_REGION = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_READ,
        S_NOP,
        S_FREE_RD,
        S_FREE_CHK
    } state_t;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_SLOT,
        RD_CUR
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_ALLOC,
        RES_READ,
        RES_FREE_OK,
        RES_FREE_RANGE,
        RES_FREE_REGION,
        RES_NOP
    } res_t;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    alloc_commit;
        logic    free_commit;
        logic    out_load;
        res_t    res_kind;
    } cmd_t;

    typedef struct packed {
        logic head_ok;
        logic high_full;
        logic cur_end;
        logic cur_bad;
        logic addr_bad;
    } stat_t;

endpackage

// ===== src/flst_req_if.sv =====
// request channel of the slot table: valid/ready handshake plus request fields
// depends on nothing
interface flst_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] code_addr;
    logic [15:0] link_value;
    logic [15:0] slot_index;
    logic [31:0] region_base;
    logic [31:0] region_bytes;

    modport source (
        output valid, req_type, code_addr, link_value, slot_index,
               region_base, region_bytes,
        input  ready
    );

    modport sink (
        input  valid, req_type, code_addr, link_value, slot_index,
               region_base, region_bytes,
        output ready
    );

endinterface

// ===== src/flst_rsp_if.sv =====
// result channel of the slot table: valid/ready handshake plus result fields
// depends on nothing
interface flst_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] slot_out;
    logic [31:0] addr_out;

    modport source (
        output valid, status, slot_out, addr_out,
        input  ready
    );

    modport sink (
        input  valid, status, slot_out, addr_out,
        output ready
    );

endinterface

// ===== src/free_list_slot_table.sv =====
// Top level of the slot table: one item at a time, result in an output register.
// Allocate, read and unused requests: S_ALLOC, S_READ or S_NOP loads the result once the output register has room.
// Free of a chain: one store read per slot, issued in S_FREE_RD and checked the cycle after in S_FREE_CHK.
// A range error on a slot is reported from S_FREE_RD, a region error on it from S_FREE_CHK.
// Reset: free list empty, high-water mark 0, no result pending; stores are not cleared.
// depends on flst_pkg, flst_req_if, flst_rsp_if, flst_ctrl and flst_datapath
module free_list_slot_table (
    input  logic      clk,
    input  logic      rst_n,
    flst_req_if.sink  req,
    flst_rsp_if.source rsp
);
    import flst_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: takes a beat only when idle, holds a finished result until the
    // output register has room; a new beat may enter while the register holds one
    flst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .req_type  (req.req_type),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: both stores share one read and one write address per cycle;
    // allocation takes the free list head first and falls back to the mark,
    // freeing pushes each walked slot onto the head of the list
    flst_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .code_addr    (req.code_addr),
        .link_value   (req.link_value),
        .slot_index   (req.slot_index),
        .region_base  (req.region_base),
        .region_bytes (req.region_bytes),
        .status       (rsp.status),
        .slot_out     (rsp.slot_out),
        .addr_out     (rsp.addr_out)
    );

endmodule

// ===== src/flst_ctrl.sv =====
// sequencing state machine of the slot table
// depends on flst_pkg and assert_macros.svh
`include "assert_macros.svh"

module flst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     req_type,
    output logic           out_valid,
    input  logic           out_ready,
    input  flst_pkg::stat_t stat,
    output flst_pkg::cmd_t  cmd
);
    import flst_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd.load_req     = 1'b0;
        cmd.rd_en        = 1'b0;
        cmd.rd_sel       = RD_CUR;
        cmd.alloc_commit = 1'b0;
        cmd.free_commit  = 1'b0;
        cmd.out_load     = 1'b0;
        cmd.res_kind     = RES_NOP;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_req = 1'b1;
                    unique case (req_t'(req_type))
                        REQ_ALLOC:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                            state_next = S_ALLOC;
                        end
                        REQ_READ:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_SLOT;
                            state_next = S_READ;
                        end
                        REQ_FREE:  state_next = S_FREE_RD;
                        REQ_NOP:   state_next = S_NOP;
                        default:   state_next = S_NOP;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.res_kind     = RES_ALLOC;
                    cmd.alloc_commit = stat.head_ok || !stat.high_full;
                    state_next       = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_READ;
                    state_next   = S_IDLE;
                end
            end
            S_NOP:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_NOP;
                    state_next   = S_IDLE;
                end
            end
            S_FREE_RD:
            begin
                if (stat.cur_end || stat.cur_bad)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.res_kind = stat.cur_end ? RES_FREE_OK : RES_FREE_RANGE;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                if (stat.addr_bad)
                begin
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.res_kind = RES_FREE_REGION;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.free_commit = 1'b1;
                    state_next      = S_FREE_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    `FLST_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != S_IDLE)
    `FLST_ASSERT_IMPL(a_load_into_free_slot, clk, rst_n, cmd.out_load, out_free)
    `FLST_ASSERT_IMPL(a_alloc_has_result, clk, rst_n, cmd.alloc_commit, cmd.out_load)

endmodule

// ===== src/flst_datapath.sv =====
// slot stores, free list head, high-water mark, chain walker and result register
// depends on flst_pkg and assert_macros.svh
`include "assert_macros.svh"

module flst_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  flst_pkg::cmd_t  cmd,
    output flst_pkg::stat_t stat,
    input  logic [31:0]     code_addr,
    input  logic [15:0]     link_value,
    input  logic [15:0]     slot_index,
    input  logic [31:0]     region_base,
    input  logic [31:0]     region_bytes,
    output logic [1:0]      status,
    output logic [15:0]     slot_out,
    output logic [31:0]     addr_out
);
    import flst_pkg::*;

    // slot stores, contents undefined until written
    logic [31:0] addr_mem [ENTRIES];
    logic [15:0] link_mem [ENTRIES];

    logic [31:0]      code_addr_reg;
    logic [15:0]      link_reg;
    logic [15:0]      idx_reg;
    logic [31:0]      base_reg;
    logic [31:0]      bytes_reg;
    logic [31:0]      rd_addr_reg;
    logic [15:0]      rd_link_reg;

    logic [15:0]      free_head_reg;
    logic [15:0]      free_head_next;
    logic [CNT_W-1:0] high_water_reg;
    logic [CNT_W-1:0] high_water_next;
    logic             high_full_reg;
    logic             high_full_next;
    logic [15:0]      cur_reg;
    logic [15:0]      cur_next;
    logic [CNT_W-1:0] freed_reg;
    logic [CNT_W-1:0] freed_next;

    logic [1:0]       status_reg;
    logic [15:0]      slot_reg;
    logic [31:0]      addr_out_reg;
    status_t          res_status;
    logic [15:0]      res_slot;
    logic [31:0]      res_addr;

    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] alloc_slot;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      wr_addr;
    logic [15:0]      wr_link;
    logic [CNT_W-1:0] hw_inc;
    logic             wr_en;
    logic             slot_ok;
    logic             alloc_ok;

    // status towards the sequencer
    assign stat.head_ok   = {1'b0, free_head_reg} < ENTRY_LIM;
    assign stat.high_full = high_full_reg;
    assign stat.cur_end   = (cur_reg == END_MARK);
    assign stat.cur_bad   = ({1'b0, cur_reg} >= ENTRY_LIM) || (freed_reg >= COUNT_LIM);
    assign stat.addr_bad  = (rd_addr_reg - base_reg) >= bytes_reg;

    assign slot_ok    = {1'b0, idx_reg} < ENTRY_LIM;
    assign alloc_ok   = stat.head_ok || !high_full_reg;
    assign alloc_slot = stat.head_ok ? free_head_reg[IDX_W-1:0] : high_water_reg[IDX_W-1:0];
    assign hw_inc     = high_water_reg + CNT_W'(1);

    // read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HEAD: rd_idx = free_head_reg[IDX_W-1:0];
            RD_SLOT: rd_idx = slot_index[IDX_W-1:0];
            RD_CUR:  rd_idx = cur_reg[IDX_W-1:0];
            default: rd_idx = cur_reg[IDX_W-1:0];
        endcase
    end

    // write port, shared by allocate and free
    assign wr_en   = cmd.alloc_commit || cmd.free_commit;
    assign wr_idx  = cmd.alloc_commit ? alloc_slot : cur_reg[IDX_W-1:0];
    assign wr_addr = cmd.alloc_commit ? code_addr_reg : 32'd0;
    assign wr_link = cmd.alloc_commit ? link_reg : free_head_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_mem[wr_idx] <= wr_addr;
            link_mem[wr_idx] <= wr_link;
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg <= addr_mem[rd_idx];
            rd_link_reg <= link_mem[rd_idx];
        end
    end

    // request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            code_addr_reg <= code_addr;
            link_reg      <= link_value;
            idx_reg       <= slot_index;
            base_reg      <= region_base;
            bytes_reg     <= region_bytes;
        end
    end

    // free list, mark and chain walker
    always_comb
    begin
        free_head_next  = free_head_reg;
        high_water_next = high_water_reg;
        high_full_next  = high_full_reg;
        cur_next        = cur_reg;
        freed_next      = freed_reg;
        if (cmd.load_req)
        begin
            cur_next   = slot_index;
            freed_next = '0;
        end
        if (cmd.alloc_commit)
        begin
            if (stat.head_ok)
                free_head_next = rd_link_reg;
            else
            begin
                high_water_next = hw_inc;
                high_full_next  = (hw_inc >= COUNT_LIM);
            end
        end
        if (cmd.free_commit)
        begin
            free_head_next = cur_reg;
            cur_next       = rd_link_reg;
            freed_next     = freed_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= END_MARK;
            high_water_reg <= '0;
            high_full_reg  <= 1'b0;
            cur_reg        <= END_MARK;
            freed_reg      <= '0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            high_water_reg <= high_water_next;
            high_full_reg  <= high_full_next;
            cur_reg        <= cur_next;
            freed_reg      <= freed_next;
        end
    end

    // result
    always_comb
    begin
        res_status = ST_OK;
        res_slot   = 16'd0;
        res_addr   = 32'd0;
        unique case (cmd.res_kind)
            RES_ALLOC:
            begin
                res_status = alloc_ok ? ST_OK : ST_FULL;
                res_slot   = alloc_ok ? 16'(alloc_slot) : 16'd0;
            end
            RES_READ:
            begin
                res_status = slot_ok ? ST_OK : ST_RANGE;
                res_slot   = idx_reg;
                res_addr   = slot_ok ? rd_addr_reg : 32'd0;
            end
            RES_FREE_RANGE:
            begin
                res_status = ST_RANGE;
                res_slot   = cur_reg;
            end
            RES_FREE_REGION:
            begin
                res_status = ST_REGION;
                res_slot   = cur_reg;
            end
            RES_FREE_OK, RES_NOP: res_status = ST_OK;
            default:              res_status = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg   <= res_status;
            slot_reg     <= res_slot;
            addr_out_reg <= res_addr;
        end
    end

    assign status   = status_reg;
    assign slot_out = slot_reg;
    assign addr_out = addr_out_reg;

    `FLST_ASSERT_NEXT(a_full_sticks, clk, rst_n, high_full_reg, high_full_reg)
    `FLST_ASSERT_IMPL(a_free_checked, clk, rst_n, cmd.free_commit, !stat.addr_bad && !stat.cur_bad && !stat.cur_end)
    `FLST_ASSERT_IMPL(a_mark_not_full, clk, rst_n, cmd.alloc_commit && !stat.head_ok, !high_full_reg)

endmodule
